// ===== hdl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

   // default sizing of the list
   localparam int PLE_CAPACITY    = 64;
   localparam int PLE_ENTRY_WIDTH = 32;

   // fixed field widths of the channels
   localparam int FUNC_W     = 2;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ   = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2
   } ple_func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } ple_status_type;

   // what the cell row does on a cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } ple_op_type;

   // per-cell control, decoded once for each cell by the row
   typedef struct packed {
      ple_op_type op;
      logic       at_pos;
      logic       past_pos;
   } ple_cell_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/ple_if.sv =====
`default_nettype none

// request channel
interface ple_req_if;
   import ple_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [POSITION_W-1:0] position;
   logic [VALUE_W-1:0]    value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink (input valid, input func, input position, input value, output ready);
endinterface

// response channel
interface ple_rsp_if;
   import ple_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] entry_out;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output entry_out, output status, output entry_count,
                   input ready);
   modport sink (input valid, input entry_out, input status, input entry_count,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/positional_list_engine.sv =====
// Ordered list of up to CAPACITY entries addressed by position.
// The request channel (req_ch) carries func, position and value; func reads,
// inserts or removes. Insert clamps the position to the count and remove to
// the count minus one. The response channel (rsp_ch) returns one transfer per
// request with the entry read or removed (zero otherwise), a status code
// (ok, list empty, list full, position out of range) and the count after the
// request.
// Entries live in a row of cells; each cell hands its entry to a neighbor, so
// the whole row shifts in the same cycle as the request transfer.
// Latency: the response is valid the cycle after the request transfer.
// Throughput: one request per cycle while responses drain, set by the row shift.
// The response sits in an output register; a new request is taken whenever
// that register is empty or is being drained in the same cycle. While the
// receiver stalls with a response pending, req_ch.ready stays low.
// Reset empties the list (count zero) and drops any pending response; entry
// contents are not cleared, since only positions below the count are read.
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY    = PLE_CAPACITY,
   parameter int ENTRY_WIDTH = PLE_ENTRY_WIDTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ple_req_if.sink    req_ch,
   ple_rsp_if.source  rsp_ch
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
   localparam int EXT_W = (ENTRY_WIDTH > VALUE_W) ? ENTRY_WIDTH : VALUE_W;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic [VALUE_W-1:0]     entry_out_ff;
   ple_status_type         status_ff;
   logic [COUNT_W-1:0]     entry_count_ff;

   logic                   req_fire;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       cnt_ext;
   logic [CMP_W-1:0]       cnt_next_ext;
   logic [CMP_W-1:0]       idx_ext;
   logic [EXT_W-1:0]       val_ext;
   logic [EXT_W-1:0]       sel_ext;
   logic [ENTRY_WIDTH-1:0] sel_data;
   ple_op_type             req_op;
   ple_op_type             cell_op;
   ple_status_type         req_status;
   logic                   take_entry;

   // request transfer whenever the output register frees up
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign pos_ext = CMP_W'(req_ch.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign val_ext = EXT_W'(req_ch.value);
   assign sel_ext = EXT_W'(sel_data);

   // decode the request against the current count
   always_comb begin
      req_op     = OP_HOLD;
      req_status = STATUS_OK;
      take_entry = 1'b0;
      idx_ext    = pos_ext;
      count_in   = count_ff;
      case (ple_func_type'(req_ch.func))
         FUNC_READ: begin
            if (pos_ext < cnt_ext) begin
               take_entry = 1'b1;
            end else begin
               req_status = STATUS_RANGE;
            end
         end
         FUNC_INSERT: begin
            if (cnt_ext == CMP_W'(CAPACITY)) begin
               req_status = STATUS_FULL;
            end else begin
               req_op   = OP_INSERT;
               idx_ext  = (pos_ext < cnt_ext) ? pos_ext : cnt_ext;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            if (count_ff == '0) begin
               req_status = STATUS_EMPTY;
            end else begin
               req_op     = OP_REMOVE;
               take_entry = 1'b1;
               idx_ext    = (pos_ext < cnt_ext - CMP_W'(1)) ? pos_ext : cnt_ext - CMP_W'(1);
               count_in   = count_ff - CNT_W'(1);
            end
         end
         default: req_status = STATUS_RANGE;
      endcase
   end

   assign cell_op      = req_fire ? req_op : OP_HOLD;
   assign cnt_next_ext = CMP_W'(count_in);

   ple_chain #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_chain (
      .clock    (clock),
      .op       (cell_op),
      .sel_idx  (idx_ext[IDX_W-1:0]),
      .value    (val_ext[ENTRY_WIDTH-1:0]),
      .sel_data (sel_data)
   );

   // count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         entry_out_ff   <= take_entry ? sel_ext[VALUE_W-1:0] : '0;
         status_ff      <= req_status;
         entry_count_ff <= cnt_next_ext[COUNT_W-1:0];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.entry_out   = entry_out_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_count = entry_count_ff;

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   // a performed insert grows the list by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cell_op == OP_INSERT) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   // failed requests return a zero entry
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_OK) |-> (entry_out_ff == '0))
      else $error("nonzero entry with error status");

   // a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_fire)
      else $error("request taken while response stalled");

endmodule

`default_nettype wire

// ===== hdl/ple_cell.sv =====
`default_nettype none

module ple_cell
   import ple_pkg::*;
#(
   parameter int ENTRY_WIDTH = PLE_ENTRY_WIDTH
) (
   input  wire logic                   clock,
   input  wire ple_cell_ctl_type       ctl,
   input  wire logic [ENTRY_WIDTH-1:0] value,
   input  wire logic [ENTRY_WIDTH-1:0] left_data,
   input  wire logic [ENTRY_WIDTH-1:0] right_data,
   output      logic [ENTRY_WIDTH-1:0] data
);

   logic [ENTRY_WIDTH-1:0] data_ff;
   logic [ENTRY_WIDTH-1:0] data_in;

   // shift up on insert, down on remove, otherwise hold
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (ctl.past_pos) begin
               data_in = left_data;
            end else if (ctl.at_pos) begin
               data_in = value;
            end
         end
         OP_REMOVE: begin
            if (ctl.past_pos || ctl.at_pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== hdl/ple_chain.sv =====
`default_nettype none

module ple_chain
   import ple_pkg::*;
#(
   parameter int CAPACITY    = PLE_CAPACITY,
   parameter int ENTRY_WIDTH = PLE_ENTRY_WIDTH,
   localparam int IDX_W      = $clog2(CAPACITY)
) (
   input  wire logic                   clock,
   input  wire ple_op_type             op,
   input  wire logic [IDX_W-1:0]       sel_idx,
   input  wire logic [ENTRY_WIDTH-1:0] value,
   output      logic [ENTRY_WIDTH-1:0] sel_data
);

   logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]    cell_hit;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ple_cell_ctl_type       ctl;
      logic [ENTRY_WIDTH-1:0] left_data;
      logic [ENTRY_WIDTH-1:0] right_data;

      // position decode local to this cell
      assign ctl.op       = op;
      assign ctl.at_pos   = (sel_idx == IDX_W'(i));
      assign ctl.past_pos = (sel_idx < IDX_W'(i));
      assign cell_hit[i]  = ctl.at_pos;

      // neighbor links, ends tied off
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ple_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .value      (value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   // and-or pick of the addressed cell
   always_comb begin
      sel_data = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         sel_data = sel_data | (cell_data[k] & {ENTRY_WIDTH{cell_hit[k]}});
      end
   end

endmodule

`default_nettype wire
